### hw/rtl/hst_pkg.sv
// shared constants, types and helper functions for the hashed symbol table
package hst_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int NAME_CHARS    = 8;

  localparam int SLOT_W      = $clog2(TABLE_ENTRIES);
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 64;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

  // home slot is hash mod (entries - 1), done by reciprocal multiply
  localparam logic [15:0] HOME_MOD   = 16'(TABLE_ENTRIES - 1);
  localparam logic [32:0] HOME_RECIP = 33'((64'd1 << 32) / (TABLE_ENTRIES - 1));

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_ADD    = 1'b1;

  typedef enum logic [1:0] {
    SC_FOUND    = 2'd0,
    SC_ABSENT   = 2'd1,
    SC_INSERTED = 2'd2,
    SC_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_HASH,
    CS_PROBE,
    CS_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic [15:0] value;
    logic [15:0] size;
    logic [7:0]  class_code;
    logic [7:0]  type_code;
    logic [63:0] name;
    logic [7:0]  ident;
  } slot_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
  } slot_req_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] home;
  } home_res_t;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] hash;
  } key_hash_t;

  // name ends at first zero byte or after NAME_CHARS bytes
  function automatic key_hash_t name_key_hash(input logic [63:0] raw);
    key_hash_t  kh;
    logic       ended;
    logic [7:0] c;
    kh    = '0;
    ended = 1'b0;
    for (int k = 0; k < 8; k++) begin
      c = raw[8*k +: 8];
      if (k < NAME_CHARS && !ended && c != 8'd0) begin
        kh.key[8*k +: 8] = c;
        kh.hash          = {kh.hash[14:0], 1'b0} + 16'(c);
      end else begin
        ended = 1'b1;
      end
    end
    return kh;
  endfunction

  function automatic logic [7:0] slot_to_index(input logic [SLOT_W-1:0] s);
    logic [15:0] w;
    w = 16'(s);
    return w[7:0];
  endfunction

endpackage

### hw/rtl/hst_home_calc.sv
// name normalization, shift-and-add hash and home slot reduction pipeline
module hst_home_calc
  import hst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] name_raw,
  output logic [63:0] key,
  output home_res_t   res
);

  key_hash_t   kh;
  logic [15:0] hash_r;
  logic [15:0] hash_d;
  logic [15:0] quot_r;
  logic [15:0] rem_r;
  logic [15:0] rem_fix;
  logic [48:0] recip_prod;
  logic [31:0] quot_mod;
  logic        v1;
  logic        v2;
  logic        v3;

  assign kh         = name_key_hash(name_raw);
  assign recip_prod = hash_r * HOME_RECIP;
  assign quot_mod   = quot_r * HOME_MOD;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key    <= kh.key;
      hash_r <= kh.hash;
    end
    // quotient estimate is exact or one short
    quot_r <= recip_prod[47:32];
    hash_d <= hash_r;
    rem_r  <= hash_d - quot_mod[15:0];
  end

  assign rem_fix  = (rem_r >= HOME_MOD) ? rem_r - HOME_MOD : rem_r;
  assign res.done = v3;
  assign res.home = rem_fix[SLOT_W-1:0];

endmodule

### hw/rtl/hst_slot_store.sv
// slot memory with registered read and per-slot valid bits cleared at reset
module hst_slot_store
  import hst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  slot_req_t   req,
  input  slot_entry_t wr_data,
  output slot_entry_t rd_data,
  output logic        rd_live
);

  slot_entry_t              mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      rd_live <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_live <= valid[req.rd_addr];
      end
    end
  end

endmodule

### hw/rtl/hashed_symbol_table_core.sv
// top level of the hashed symbol table: probe sequencer and result register
//
//   channel   | dir | tdata                                   | tuser
//   ----------+-----+-----------------------------------------+--------
//   s_*       | in  | name, ident, type, class, size, value   | func
//   m_*       | out | slot_index, ident, type, class, size,   | status
//             |     | value                                   |
//
// one item at a time: n slots are probed per item (1 up to TABLE_ENTRIES),
// one probe per memory read; the hash and home reduction finish before
// the first read.
// reset clears the valid bits of all slots at once, no clearing pass.
// a new item is taken while the previous result waits in m_tdata.
module hashed_symbol_table_core
  import hst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // name_chars[63:0], entry_ident, entry_type, entry_class, entry_size, entry_value
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // func
  input  logic [0:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // slot_index, out_ident, out_type, out_class, out_size, out_value
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // status
  output logic [1:0]             m_tuser
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_next;
  logic [SLOT_W-1:0] home_r;
  logic [SLOT_W-1:0] home_next;
  logic [SLOT_W-1:0] slot_step;
  logic              func_r;
  slot_entry_t       add_r;
  status_t           res_status;
  status_t           res_status_next;
  logic [7:0]        res_slot;
  logic [7:0]        res_slot_next;
  slot_entry_t       res_entry;
  slot_entry_t       res_entry_next;

  logic        hash_start;
  logic [63:0] key;
  home_res_t   hres;
  slot_req_t   req;
  slot_entry_t wr_data;
  slot_entry_t rd_data;
  logic        rd_live;
  logic        occupied;
  logic        name_hit;
  logic        load_out;

  hst_home_calc u_home_calc (
    .clk      (clk),
    .rst      (rst),
    .start    (hash_start),
    .name_raw (s_tdata[63:0]),
    .key      (key),
    .res      (hres)
  );

  hst_slot_store u_slot_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .rd_live (rd_live)
  );

  assign occupied  = rd_live && (rd_data.ident != 8'd0);
  assign name_hit  = (rd_data.name == key);
  assign slot_step = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hash_start) begin
      func_r           <= s_tuser[0];
      add_r.name       <= s_tdata[63:0];
      add_r.ident      <= s_tdata[71:64];
      add_r.type_code  <= s_tdata[79:72];
      add_r.class_code <= s_tdata[87:80];
      add_r.size       <= s_tdata[103:88];
      add_r.value      <= s_tdata[119:104];
    end
    slot_r     <= slot_next;
    home_r     <= home_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_entry  <= res_entry_next;
  end

  // the insert write lands at the end of an item; the next item's first
  // read comes after its hash, so reads and writes never overlap
  always_comb begin
    state_next      = state;
    slot_next       = slot_r;
    home_next       = home_r;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_entry_next  = res_entry;
    req             = '0;
    wr_data         = add_r;
    wr_data.name    = key;
    hash_start      = 1'b0;
    s_tready        = 1'b0;
    load_out        = 1'b0;
    case (state)
      CS_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          hash_start = 1'b1;
          state_next = CS_HASH;
        end
      end
      CS_HASH: begin
        if (hres.done) begin
          req.rd_en   = 1'b1;
          req.rd_addr = hres.home;
          slot_next   = hres.home;
          home_next   = hres.home;
          state_next  = CS_PROBE;
        end
      end
      CS_PROBE: begin
        if (!occupied) begin
          state_next     = CS_EMIT;
          res_slot_next  = '0;
          res_entry_next = '0;
          if (func_r == FUNC_ADD) begin
            req.wr_en       = 1'b1;
            req.wr_addr     = slot_r;
            res_status_next = SC_INSERTED;
            res_slot_next   = slot_to_index(slot_r);
            res_entry_next  = wr_data;
          end else begin
            res_status_next = SC_ABSENT;
          end
        end else if (name_hit) begin
          state_next      = CS_EMIT;
          res_status_next = SC_FOUND;
          res_slot_next   = slot_to_index(slot_r);
          res_entry_next  = rd_data;
        end else if (slot_step == home_r) begin
          // wrapped back to home: table full
          state_next     = CS_EMIT;
          res_slot_next  = '0;
          res_entry_next = '0;
          if (func_r == FUNC_ADD) begin
            res_status_next = SC_OVERFLOW;
          end else begin
            res_status_next = SC_ABSENT;
          end
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = slot_step;
          slot_next   = slot_step;
        end
      end
      CS_EMIT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= res_status;
      m_tdata <= {res_entry.value, res_entry.size, res_entry.class_code,
                  res_entry.type_code, res_entry.ident, res_slot};
    end
  end

endmodule

### hw/rtl/hst_checker.sv
// port-level checks for the hashed symbol table, bound to the top level
module hst_checker
  import hst_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic [0:0]             s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [1:0]             m_tuser
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] in_flight;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_one_item_in_work: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_tready)
    else $error("input taken again right after an accept");

  a_no_excess_items: assert property (@(posedge clk) disable iff (rst)
    (in_flight <= 2'd2) && !(out_acc && in_flight == 2'd0))
    else $error("result count does not match accepted items");

  a_miss_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == SC_ABSENT || m_tuser == SC_OVERFLOW))
      |-> (m_tdata == '0))
    else $error("absent or overflow result carries entry data");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind hashed_symbol_table_core hst_checker u_hst_checker (.*);
